// File: sv/d2c_pkg.sv
// Package for the delta-to-CIGAR encoder: item kinds, CIGAR operation codes,
// and the structs passed between the input stage, the core and the output stage.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package d2c_pkg;

  // Kind of input word. The fourth code carries no meaning and is dropped.
  typedef enum logic [1:0] {
    ITEM_BEGIN  = 2'd0,
    ITEM_DELTA  = 2'd1,
    ITEM_FINISH = 2'd2
  } item_kind_e;

  typedef enum logic [2:0] {
    CIG_M   = 3'd0,
    CIG_I   = 3'd1,
    CIG_D   = 3'd2,
    CIG_S   = 3'd3,
    CIG_H   = 3'd4,
    CIG_END = 3'd5
  } cigar_op_e;

  // One input word can produce up to four operations, always in this slot order.
  localparam int unsigned NumSlots  = 4;
  localparam int unsigned SlotIdxW  = $clog2(NumSlots);
  localparam int unsigned SlotLead  = 0;  // pending indel flush or leading clip
  localparam int unsigned SlotMatch = 1;  // M run
  localparam int unsigned SlotTail  = 2;  // trailing clip
  localparam int unsigned SlotEnd   = 3;  // end-of-record marker

  // Input word after predecode of the delta value.
  typedef struct packed {
    item_kind_e  kind;
    logic        neg;        // negative delta, or zero delta
    logic        unit;       // delta of +1 or -1
    logic [31:0] mlen;       // M length that a non-merging delta emits
    logic [31:0] addend;     // query positions that a non-merging delta consumes
    logic [31:0] start_pos;
    logic [31:0] end_pos;
    logic [31:0] total_len;
    logic        clip_kind;
  } d2c_item_t;

  typedef struct packed {
    logic      valid;
    d2c_item_t item;
  } d2c_stage_t;

  typedef struct packed {
    cigar_op_e   op;
    logic [31:0] len;
  } d2c_result_t;

  typedef struct packed {
    logic [NumSlots-1:0]        mask;
    d2c_result_t [NumSlots-1:0] slot;
  } d2c_bundle_t;

endpackage : d2c_pkg

`default_nettype wire

// File: sv/d2c_in_stage.sv
// Input register of the delta-to-CIGAR encoder, with predecode of the delta value.
// Depends on d2c_pkg.
`timescale 1ns / 1ps
`default_nettype none

module d2c_in_stage
  import d2c_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [1:0]         op_i,
  input  wire logic signed [31:0] delta_value_i,
  input  wire logic [31:0]        start_pos_i,
  input  wire logic [31:0]        end_pos_i,
  input  wire logic [31:0]        total_len_i,
  input  wire logic               clip_kind_i,
  input  wire logic               advance_i,
  output d2c_stage_t              stage_o
);

  logic      valid_q, valid_d;
  d2c_item_t item_q, item_d;
  logic      accept;
  logic      zero, neg_raw;

  assign in_stall_o = valid_q && !advance_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign valid_d    = accept || (valid_q && !advance_i);

  // A negative delta d emits M of |d|-1, which is ~d, and consumes |d| positions.
  // A zero delta counts as negative but never merges: M of 0, one position consumed.
  always_comb begin
    zero    = (delta_value_i == 32'sd0);
    neg_raw = delta_value_i[31];
    item_d.kind      = item_kind_e'(op_i);
    item_d.neg       = neg_raw || zero;
    item_d.unit      = (delta_value_i == 32'sd1) || (delta_value_i == -32'sd1);
    item_d.start_pos = start_pos_i;
    item_d.end_pos   = end_pos_i;
    item_d.total_len = total_len_i;
    item_d.clip_kind = clip_kind_i;
    if (zero) begin
      item_d.mlen   = 32'd0;
      item_d.addend = 32'd1;
    end else if (neg_raw) begin
      item_d.mlen   = ~delta_value_i;
      item_d.addend = ~delta_value_i + 32'd1;
    end else begin
      item_d.mlen   = delta_value_i - 32'd1;
      item_d.addend = delta_value_i - 32'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.item  = item_q;

endmodule : d2c_in_stage

`default_nettype wire

// File: sv/d2c_core.sv
// Record state and operation generation of the delta-to-CIGAR encoder: turns one
// registered input word into a bundle of up to four operations. Depends on d2c_pkg.
`timescale 1ns / 1ps
`default_nettype none

module d2c_core
  import d2c_pkg::*;
#(
  parameter int POS_BITS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire d2c_stage_t  stage_i,
  input  wire logic        ready_i,
  output logic             advance_o,
  output logic             load_o,
  output d2c_bundle_t      bundle_o
);

  localparam int WideW = (POS_BITS > 32) ? POS_BITS : 32;

  // Clamp a 32-bit position into the saturating position range.
  function automatic logic [POS_BITS-1:0] clamp_pos(input logic [31:0] x);
    logic [WideW-1:0] xw;
    xw = WideW'(x);
    return ((xw >> POS_BITS) != '0) ? '1 : xw[POS_BITS-1:0];
  endfunction

  // consumed_q already includes the pending run when that run is an insertion,
  // so a flush never has to add to it.
  logic [POS_BITS-1:0] end_hold_q, end_hold_d;
  logic                clip_hold_q, clip_hold_d;
  logic                tail_pend_q, tail_pend_d;
  logic [POS_BITS-1:0] tail_len_q, tail_len_d;
  logic                run_neg_q, run_neg_d;
  logic [POS_BITS-1:0] run_mag_q, run_mag_d;
  logic [POS_BITS-1:0] consumed_q, consumed_d;

  d2c_item_t           item;
  logic [POS_BITS-1:0] startc, endc, lenc, mlenc, addendc;
  logic                start_gt1;
  logic [POS_BITS:0]   tail_diff, fin_diff;
  logic [POS_BITS:0]   run_sum, cons1_sum, cons_sum;
  logic [POS_BITS-1:0] run_inc, cons_inc, cons_add;
  logic                run_pend, merge, fin_m, has_res;
  cigar_op_e           flush_op;

  always_comb begin
    item      = stage_i.item;
    startc    = clamp_pos(item.start_pos);
    endc      = clamp_pos(item.end_pos);
    lenc      = clamp_pos(item.total_len);
    mlenc     = clamp_pos(item.mlen);
    addendc   = clamp_pos(item.addend);
    start_gt1 = (startc[POS_BITS-1:1] != '0);
    tail_diff = {1'b0, lenc} - {1'b0, endc};
    fin_diff  = {1'b0, end_hold_q} - {1'b0, consumed_q};
    fin_m     = !fin_diff[POS_BITS] && (fin_diff[POS_BITS-1:0] != '0);

    run_sum   = {1'b0, run_mag_q} + (POS_BITS+1)'(1);
    cons1_sum = {1'b0, consumed_q} + (POS_BITS+1)'(1);
    cons_sum  = {1'b0, consumed_q} + {1'b0, addendc};
    run_inc   = run_sum[POS_BITS] ? '1 : run_sum[POS_BITS-1:0];
    cons_inc  = cons1_sum[POS_BITS] ? '1 : cons1_sum[POS_BITS-1:0];
    cons_add  = cons_sum[POS_BITS] ? '1 : cons_sum[POS_BITS-1:0];

    run_pend  = (run_mag_q != '0);
    merge     = item.unit && (!run_pend || (run_neg_q == item.neg));
    flush_op  = run_neg_q ? CIG_I : CIG_D;
  end

  always_comb begin
    bundle_o    = '0;
    end_hold_d  = end_hold_q;
    clip_hold_d = clip_hold_q;
    tail_pend_d = tail_pend_q;
    tail_len_d  = tail_len_q;
    run_neg_d   = run_neg_q;
    run_mag_d   = run_mag_q;
    consumed_d  = consumed_q;
    case (item.kind)
      ITEM_BEGIN: begin
        end_hold_d  = endc;
        clip_hold_d = item.clip_kind;
        tail_pend_d = !tail_diff[POS_BITS] && (tail_diff[POS_BITS-1:0] != '0);
        tail_len_d  = tail_diff[POS_BITS-1:0];
        run_neg_d   = 1'b0;
        run_mag_d   = '0;
        consumed_d  = start_gt1 ? (startc - POS_BITS'(1)) : '0;
        bundle_o.mask[SlotLead]     = start_gt1;
        bundle_o.slot[SlotLead].op  = item.clip_kind ? CIG_H : CIG_S;
        bundle_o.slot[SlotLead].len = 32'(startc - POS_BITS'(1));
      end
      ITEM_DELTA: begin
        if (merge) begin
          run_neg_d  = item.neg;
          run_mag_d  = run_inc;
          consumed_d = item.neg ? cons_inc : consumed_q;
        end else begin
          run_neg_d  = item.neg;
          run_mag_d  = POS_BITS'(1);
          consumed_d = cons_add;
          bundle_o.mask[SlotLead]      = run_pend;
          bundle_o.slot[SlotLead].op   = flush_op;
          bundle_o.slot[SlotLead].len  = 32'(run_mag_q);
          bundle_o.mask[SlotMatch]     = 1'b1;
          bundle_o.slot[SlotMatch].op  = CIG_M;
          bundle_o.slot[SlotMatch].len = 32'(mlenc);
        end
      end
      ITEM_FINISH: begin
        run_neg_d = 1'b0;
        run_mag_d = '0;
        bundle_o.mask[SlotLead]      = run_pend;
        bundle_o.slot[SlotLead].op   = flush_op;
        bundle_o.slot[SlotLead].len  = 32'(run_mag_q);
        bundle_o.mask[SlotMatch]     = fin_m;
        bundle_o.slot[SlotMatch].op  = CIG_M;
        bundle_o.slot[SlotMatch].len = 32'(fin_diff[POS_BITS-1:0]);
        bundle_o.mask[SlotTail]      = tail_pend_q;
        bundle_o.slot[SlotTail].op   = clip_hold_q ? CIG_H : CIG_S;
        bundle_o.slot[SlotTail].len  = 32'(tail_len_q);
        bundle_o.mask[SlotEnd]       = 1'b1;
        bundle_o.slot[SlotEnd].op    = CIG_END;
        bundle_o.slot[SlotEnd].len   = 32'd0;
      end
      default: begin
        bundle_o = '0;
      end
    endcase
  end

  // A word that yields no operation updates the state without waiting for the output.
  assign has_res   = |bundle_o.mask;
  assign advance_o = stage_i.valid && (!has_res || ready_i);
  assign load_o    = stage_i.valid && has_res && ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      end_hold_q  <= '0;
      clip_hold_q <= 1'b0;
      tail_pend_q <= 1'b0;
      tail_len_q  <= '0;
      run_neg_q   <= 1'b0;
      run_mag_q   <= '0;
      consumed_q  <= '0;
    end else if (advance_o) begin
      end_hold_q  <= end_hold_d;
      clip_hold_q <= clip_hold_d;
      tail_pend_q <= tail_pend_d;
      tail_len_q  <= tail_len_d;
      run_neg_q   <= run_neg_d;
      run_mag_q   <= run_mag_d;
      consumed_q  <= consumed_d;
    end
  end

endmodule : d2c_core

`default_nettype wire

// File: sv/d2c_out_stage.sv
// Output side of the delta-to-CIGAR encoder; depends on d2c_pkg. Holds one operation
// bundle; its operations enter the output register one per cycle unless stalled.
`timescale 1ns / 1ps
`default_nettype none

module d2c_out_stage
  import d2c_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        load_i,
  input  wire d2c_bundle_t bundle_i,
  output logic             ready_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       cigar_op_o,
  output logic [31:0]      op_length_o,
  output logic             last_o
);

  logic [NumSlots-1:0]        mask_q, mask_d;
  d2c_result_t [NumSlots-1:0] slot_q;
  logic                       o_valid_q, o_valid_d;
  d2c_result_t                o_res_q;
  logic                       o_last_q;
  logic [SlotIdxW-1:0]        sel;
  logic [NumSlots-1:0]        rest;
  logic                       move;

  always_comb begin
    sel = '0;
    for (int i = NumSlots - 1; i >= 0; i--) begin
      if (mask_q[i]) begin
        sel = SlotIdxW'(i);
      end
    end
    rest      = mask_q;
    rest[sel] = 1'b0;
  end

  // The next bundle may enter in the same cycle that the last pending operation
  // moves to the output register.
  assign move      = (|mask_q) && (!o_valid_q || !out_stall_i);
  assign ready_o   = !(|mask_q) || (move && !(|rest));
  assign mask_d    = load_i ? bundle_i.mask : (move ? rest : mask_q);
  assign o_valid_d = move || (o_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q    <= '0;
      o_valid_q <= 1'b0;
    end else begin
      mask_q    <= mask_d;
      o_valid_q <= o_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      slot_q <= bundle_i.slot;
    end
    if (move) begin
      o_res_q  <= slot_q[sel];
      o_last_q <= !(|rest);
    end
  end

  assign out_valid_o = o_valid_q;
  assign cigar_op_o  = o_res_q.op;
  assign op_length_o = o_res_q.len;
  assign last_o      = o_last_q;

endmodule : d2c_out_stage

`default_nettype wire

// File: sv/delta_to_cigar_encoder.sv
// Channel  Direction  Handshake                  Payload
// input    in         in_valid_i / in_stall_o    op, delta_value, start_pos, end_pos,
//                                                total_len, clip_kind
// output   out        out_valid_o / out_stall_i  cigar_op, op_length, last
//
// A word is registered in the input register on acceptance; the core turns it into a
// bundle of operations, loaded into the output stage once that stage is ready. Each
// operation a word yields (zero to four; a delta word yields at most two) then takes
// its turn in the single output register, which sets the rate; a word yielding none
// never reaches the output stage. The next word may be taken meanwhile.
// Reset clears the record state to zero and empties all stages.
// A stall on the output holds the current word; the input stalls while the input
// register holds a word with operations that the output stage cannot yet take.
//
// Top level of the delta-to-CIGAR encoder. Depends on d2c_pkg, d2c_in_stage,
// d2c_core and d2c_out_stage.
`timescale 1ns / 1ps
`default_nettype none

module delta_to_cigar_encoder
  import d2c_pkg::*;
#(
  parameter int POS_BITS = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [1:0]         op_i,
  input  wire logic signed [31:0] delta_value_i,
  input  wire logic [31:0]        start_pos_i,
  input  wire logic [31:0]        end_pos_i,
  input  wire logic [31:0]        total_len_i,
  input  wire logic               clip_kind_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [2:0]              cigar_op_o,
  output logic [31:0]             op_length_o,
  output logic                    last_o
);

  d2c_stage_t  stage;
  d2c_bundle_t bundle;
  logic        advance, load, ready;

  d2c_in_stage u_in_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (op_i),
    .delta_value_i (delta_value_i),
    .start_pos_i   (start_pos_i),
    .end_pos_i     (end_pos_i),
    .total_len_i   (total_len_i),
    .clip_kind_i   (clip_kind_i),
    .advance_i     (advance),
    .stage_o       (stage)
  );

  d2c_core #(
    .POS_BITS (POS_BITS)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .stage_i   (stage),
    .ready_i   (ready),
    .advance_o (advance),
    .load_o    (load),
    .bundle_o  (bundle)
  );

  d2c_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .bundle_i    (bundle),
    .ready_o     (ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cigar_op_o  (cigar_op_o),
    .op_length_o (op_length_o),
    .last_o      (last_o)
  );

endmodule : delta_to_cigar_encoder

`default_nettype wire

// File: sv/d2c_checker.sv
// Port-level checks for the delta-to-CIGAR encoder, bound to its top level.
// Depends on d2c_pkg and delta_to_cigar_encoder.
`timescale 1ns / 1ps
`default_nettype none

module d2c_checker
  import d2c_pkg::*;
(
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire logic [1:0]         op_i,
  input wire logic signed [31:0] delta_value_i,
  input wire logic [31:0]        start_pos_i,
  input wire logic [31:0]        end_pos_i,
  input wire logic [31:0]        total_len_i,
  input wire logic               clip_kind_i,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire logic [2:0]         cigar_op_o,
  input wire logic [31:0]        op_length_o,
  input wire logic               last_o
);

  // A stalled output word stays valid and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(cigar_op_o)
      && $stable(op_length_o) && $stable(last_o))
    else $error("output word changed while stalled");

  // The end-of-record marker closes its word and has zero length.
  a_end_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (cigar_op_o == CIG_END) |-> last_o && (op_length_o == 32'd0))
    else $error("end marker without last or with nonzero length");

  // The remaining operations of a word follow without a gap.
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |=> out_valid_o)
    else $error("gap inside the operations of one word");

  // An input stall with an empty output register means a bundle is waiting to drain.
  a_stall_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o && !out_valid_o |=> out_valid_o)
    else $error("input stalled while the output stayed empty");

endmodule : d2c_checker

bind delta_to_cigar_encoder d2c_checker u_d2c_checker (.*);

`default_nettype wire
